// ----- rtl/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg: shared types for the sorted priority queue
// Operation and status codes, field widths and the per-cell control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned OCC_W  = 5;

    // operation requested by an input request
    typedef enum logic [1:0] {
        MODE_ENQ   = 2'd0,
        MODE_DEQ   = 2'd1,
        MODE_PEEK  = 2'd2,
        MODE_CLEAR = 2'd3
    } mode_t;

    // result status
    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    // control broadcast to every cell in the chain
    typedef struct packed {
        logic enq;   // insert the new entry at its sorted place
        logic deq;   // every cell takes its right neighbor's entry
    } cell_ctrl_t;

endpackage : spq_pkg

`default_nettype wire

// ----- rtl/spq_cell.sv -----
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted chain
// Holds one entry, compares its priority against the incoming one and picks
// its next entry from itself, the new request or a neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell (
    input  wire logic                                clk,
    input  wire spq_pkg::cell_ctrl_t                 ctrl,
    input  wire logic                                occupied,
    input  wire logic signed [spq_pkg::DATA_W-1:0]   new_value,
    input  wire logic signed [spq_pkg::DATA_W-1:0]   new_priority,
    input  wire logic                                ge_prev,
    input  wire logic signed [spq_pkg::DATA_W-1:0]   prev_value,
    input  wire logic signed [spq_pkg::DATA_W-1:0]   prev_priority,
    input  wire logic signed [spq_pkg::DATA_W-1:0]   next_value,
    input  wire logic signed [spq_pkg::DATA_W-1:0]   next_priority,
    output logic                                     ge,
    output logic signed [spq_pkg::DATA_W-1:0]        value,
    output logic signed [spq_pkg::DATA_W-1:0]        entry_priority
);

    logic signed [spq_pkg::DATA_W-1:0] value_reg;
    logic signed [spq_pkg::DATA_W-1:0] value_next;
    logic signed [spq_pkg::DATA_W-1:0] priority_reg;
    logic signed [spq_pkg::DATA_W-1:0] priority_next;

    // entry stays ahead of the new one when its priority is not lower
    assign ge = occupied && !(priority_reg < new_priority);

    // next entry selection
    always_comb
    begin
        value_next    = value_reg;
        priority_next = priority_reg;
        priority if (ctrl.enq)
        begin
            if (ge)
            begin
                value_next    = value_reg;
                priority_next = priority_reg;
            end
            else if (ge_prev)
            begin
                value_next    = new_value;
                priority_next = new_priority;
            end
            else
            begin
                value_next    = prev_value;
                priority_next = prev_priority;
            end
        end
        else if (ctrl.deq)
        begin
            value_next    = next_value;
            priority_next = next_priority;
        end
    end

    // entry storage, payload only
    always_ff @(posedge clk)
    begin
        value_reg    <= value_next;
        priority_reg <= priority_next;
    end

    assign value          = value_reg;
    assign entry_priority = priority_reg;

endmodule : spq_cell

`default_nettype wire

// ----- rtl/sorted_priority_queue_core.sv -----
// ----------------------------------------------------------------------------
// sorted_priority_queue_core: bounded max-priority queue
// A chain of DEPTH cells kept sorted by descending priority, ties in
// arrival order. Enqueue, dequeue, peek and clear each give one result.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request per transfer: tuser holds the operation,
//   tdata the value and priority to enqueue (ignored by other operations).
//   m_axis returns one result per request: tuser holds the status, tdata
//   the removed or peeked value and the occupancy after the operation.
//   Every cell compares its priority with the incoming one in parallel and
//   shifts toward its neighbor in the same cycle, so a request is executed
//   in the cycle it is accepted and its result is registered; one request
//   is taken every cycle while results drain.
//   The result register is the only buffer: when the receiver stalls with
//   a result pending, s_axis_tready drops until that result is taken.
//   Reset empties the queue (occupancy 0) and clears the result valid;
//   the cell contents are not reset and are never read before written.
//   An enqueue into a full queue is refused with status full; dequeue or
//   peek on an empty queue returns status empty and a zero value.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue_core #(
    parameter int unsigned DEPTH = 16
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    // request channel
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [63:0]  s_axis_tdata,   // item_value[31:0], item_priority[63:32]
    input  wire logic [1:0]   s_axis_tuser,   // mode[1:0]
    // result channel
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [39:0]       m_axis_tdata,   // head_value[31:0], occupancy[36:32], zero[39:37]
    output logic [1:0]        m_axis_tuser    // status[1:0]
);

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam int unsigned DW    = spq_pkg::DATA_W;

    spq_pkg::mode_t       mode;
    spq_pkg::cell_ctrl_t  ctrl;
    logic                 accept;
    logic                 full;
    logic                 empty;

    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [DW-1:0]        out_value_reg;
    logic [DW-1:0]        out_value_next;
    spq_pkg::status_t     out_status_reg;
    spq_pkg::status_t     out_status_next;
    logic [spq_pkg::OCC_W-1:0] out_occ_reg;
    logic [spq_pkg::OCC_W-1:0] out_occ_next;
    logic [CNT_W+spq_pkg::OCC_W-1:0] count_ext;

    logic signed [DW-1:0] new_value;
    logic signed [DW-1:0] new_priority;
    logic signed [DW-1:0] cell_value    [DEPTH];
    logic signed [DW-1:0] cell_priority [DEPTH];
    logic                 cell_ge       [DEPTH];

    assign mode         = spq_pkg::mode_t'(s_axis_tuser);
    assign new_value    = $signed(s_axis_tdata[DW-1:0]);
    assign new_priority = $signed(s_axis_tdata[2*DW-1:DW]);

    // handshake: the result register frees up when its result is taken
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);

    // cell control for this cycle
    always_comb
    begin
        ctrl.enq = accept && (mode == spq_pkg::MODE_ENQ) && !full;
        ctrl.deq = accept && (mode == spq_pkg::MODE_DEQ) && !empty;
    end

    // cell chain
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic                 occ;
        logic                 ge_left;
        logic signed [DW-1:0] left_value;
        logic signed [DW-1:0] left_priority;
        logic signed [DW-1:0] right_value;
        logic signed [DW-1:0] right_priority;

        assign occ = (count_reg > CNT_W'(i));

        if (i == 0)
        begin : g_first
            assign ge_left       = 1'b1;
            assign left_value    = new_value;
            assign left_priority = new_priority;
        end
        else
        begin : g_mid
            assign ge_left       = cell_ge[i-1];
            assign left_value    = cell_value[i-1];
            assign left_priority = cell_priority[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_value    = '0;
            assign right_priority = '0;
        end
        else
        begin : g_inner
            assign right_value    = cell_value[i+1];
            assign right_priority = cell_priority[i+1];
        end

        spq_cell u_cell (
            .clk            (clk),
            .ctrl           (ctrl),
            .occupied       (occ),
            .new_value      (new_value),
            .new_priority   (new_priority),
            .ge_prev        (ge_left),
            .prev_value     (left_value),
            .prev_priority  (left_priority),
            .next_value     (right_value),
            .next_priority  (right_priority),
            .ge             (cell_ge[i]),
            .value          (cell_value[i]),
            .entry_priority (cell_priority[i])
        );
    end

    // occupancy update and result formation
    always_comb
    begin
        count_next      = count_reg;
        out_value_next  = '0;
        out_status_next = spq_pkg::STATUS_OK;
        if (accept)
        begin
            unique case (mode)
                spq_pkg::MODE_ENQ:
                begin
                    if (full)
                        out_status_next = spq_pkg::STATUS_FULL;
                    else
                        count_next = count_reg + CNT_W'(1);
                end
                spq_pkg::MODE_DEQ:
                begin
                    if (empty)
                        out_status_next = spq_pkg::STATUS_EMPTY;
                    else
                    begin
                        out_value_next = cell_value[0];
                        count_next     = count_reg - CNT_W'(1);
                    end
                end
                spq_pkg::MODE_PEEK:
                begin
                    if (empty)
                        out_status_next = spq_pkg::STATUS_EMPTY;
                    else
                        out_value_next = cell_value[0];
                end
                spq_pkg::MODE_CLEAR:
                begin
                    count_next = '0;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    assign count_ext    = {{spq_pkg::OCC_W{1'b0}}, count_next};
    assign out_occ_next = count_ext[spq_pkg::OCC_W-1:0];

    // result valid tracking
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_value_reg  <= out_value_next;
            out_status_reg <= out_status_next;
            out_occ_reg    <= out_occ_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_occ_reg, out_value_reg};
    assign m_axis_tuser  = out_status_reg;

endmodule : sorted_priority_queue_core

`default_nettype wire

// ----- rtl/spq_checker.sv -----
// ----------------------------------------------------------------------------
// spq_checker: port-level checks for the sorted priority queue
// Watches the request and result channels and flags inconsistent results.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_checker #(
    parameter int unsigned DEPTH = 16
) (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [39:0] m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser
);

    localparam logic [4:0] DEPTH_LOW = 5'(DEPTH);

    // stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // requests are always taken when no result is pending
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("request blocked with empty result register");

    // empty status carries zero value and zero occupancy
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == spq_pkg::STATUS_EMPTY) |->
            (m_axis_tdata[36:0] == 37'd0))
        else $error("empty status with nonzero value or occupancy");

    // full status carries zero value and a full count
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == spq_pkg::STATUS_FULL) |->
            (m_axis_tdata[31:0] == 32'd0) && (m_axis_tdata[36:32] == DEPTH_LOW))
        else $error("full status with wrong value or occupancy");

    // occupancy never exceeds the capacity; checked for DEPTH up to 31
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (DEPTH > 31) || (m_axis_tdata[36:32] <= DEPTH_LOW))
        else $error("occupancy beyond capacity");

endmodule : spq_checker

bind sorted_priority_queue_core spq_checker #(.DEPTH(DEPTH)) u_spq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
